// File: hdl/fra_pkg.sv
// ----------------------------------------------------------------------------
// fra_pkg
// Shared types and codes for the fraction reduce and accumulate block.
// ----------------------------------------------------------------------------
package fra_pkg;

    // divider operand pairs
    localparam logic [1:0] DIV_GCD = 2'd0;   // a % b
    localparam logic [1:0] DIV_NUM = 2'd1;   // num / g
    localparam logic [1:0] DIV_DEN = 2'd2;   // den / g

    // multiplier operand pairs
    localparam logic [1:0] MUL_SN_RD = 2'd0;
    localparam logic [1:0] MUL_SD_RN = 2'd1;
    localparam logic [1:0] MUL_SD_RD = 2'd2;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic [1:0] div_sel;
        logic       div_step;
        logic       gcd_next;
        logic       take_g;
        logic       take_rn;
        logic       take_rd;
        logic       pass_zoz;
        logic       mul_lo;
        logic       mul_hi;
        logic       mul_cmb;
        logic [1:0] mul_sel;
        logic       commit;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic b_zero;
        logic g_zero;
        logic ovf;
    } t_stat;

endpackage

// File: hdl/fra_dp.sv
// ----------------------------------------------------------------------------
// fra_dp
// Datapath: gcd registers, shared restoring divider, split multiplier,
// running sum and output register.
// ----------------------------------------------------------------------------
module fra_dp #(
    parameter int PART_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fra_pkg::t_cmd i_cmd,
    output fra_pkg::t_stat o_stat,
    input  logic [15:0]   i_num,
    input  logic [15:0]   i_den,
    input  logic          i_clr,
    output logic [159:0]  o_data,
    output logic [1:0]    o_user
);
    import fra_pkg::*;

    localparam int W = PART_WIDTH;

    logic [W-1:0] r_num, r_den, r_a, r_b, r_g, r_rn, r_rd;
    logic [W-1:0] r_rem, r_quo, r_dvs;
    logic [63:0]  r_sn, r_sd, r_t1, r_t2, r_nd;
    logic         r_ovf, r_fit, r_zoz;
    logic [31+W:0] r_plo, r_phi;
    logic [159:0] r_odata;
    logic [1:0]   r_ouser;

    logic [W:0]    w_shift;
    logic          w_ge;
    logic [W-1:0]  w_dvd, w_dvs;
    logic [63:0]   w_ma;
    logic [W-1:0]  w_mb;
    logic [31:0]   w_half;
    logic [31+W:0] w_prod;
    logic [63+W:0] w_full;
    logic          w_fits;
    logic [64:0]   w_nn;

    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_NUM: begin w_dvd = r_num; w_dvs = r_g; end
            DIV_DEN: begin w_dvd = r_den; w_dvs = r_g; end
            default: begin w_dvd = r_a;   w_dvs = r_b; end
        endcase
    end

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_SN_RD: begin w_ma = r_sn; w_mb = r_rd; end
            MUL_SD_RN: begin w_ma = r_sd; w_mb = r_rn; end
            default:   begin w_ma = r_sd; w_mb = r_rd; end
        endcase
    end

    assign w_half = i_cmd.mul_hi ? w_ma[63:32] : w_ma[31:0];
    assign w_prod = (32+W)'(w_half) * (32+W)'(w_mb);
    assign w_full = {r_phi, 32'b0} + (64+W)'(r_plo);
    assign w_fits = (w_full[63+W:64] == '0);
    assign w_nn   = {1'b0, r_t1} + {1'b0, r_t2};

    // running sum and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sn  <= 64'd0;
            r_sd  <= 64'd1;
            r_ovf <= 1'b0;
        end else if (i_cmd.load && i_clr) begin
            r_sn  <= 64'd0;
            r_sd  <= 64'd1;
            r_ovf <= 1'b0;
        end else if (i_cmd.commit) begin
            if (r_fit && !w_nn[64]) begin
                r_sn <= w_nn[63:0];
                r_sd <= r_nd;
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num <= W'(i_num);
            r_den <= W'(i_den);
            r_a   <= W'(i_num);
            r_b   <= W'(i_den);
            r_zoz <= 1'b0;
            r_fit <= 1'b1;
        end
        if (i_cmd.gcd_next) begin
            r_a <= r_b;
            r_b <= r_rem;
        end
        if (i_cmd.take_g) r_g <= r_a;
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= w_dvd;
            r_dvs <= w_dvs;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? W'(w_shift - {1'b0, r_dvs}) : w_shift[W-1:0];
            r_quo <= {r_quo[W-2:0], w_ge};
        end
        if (i_cmd.take_rn) r_rn <= r_quo;
        if (i_cmd.take_rd) r_rd <= r_quo;
        if (i_cmd.pass_zoz) begin
            r_rn  <= r_num;
            r_rd  <= r_den;
            r_zoz <= 1'b1;
        end
        if (i_cmd.mul_lo) r_plo <= w_prod;
        if (i_cmd.mul_hi) r_phi <= w_prod;
        if (i_cmd.mul_cmb) begin
            r_fit <= r_fit & w_fits;
            unique case (i_cmd.mul_sel)
                MUL_SN_RD: r_t1 <= w_full[63:0];
                MUL_SD_RN: r_t2 <= w_full[63:0];
                default:   r_nd <= w_full[63:0];
            endcase
        end
        if (i_cmd.out_load) begin
            r_odata <= {r_sd, r_sn, 16'(r_rd), 16'(r_rn)};
            r_ouser <= {r_zoz, r_ovf};
        end
    end

    assign o_stat.b_zero = (r_b == '0);
    assign o_stat.g_zero = (r_g == '0);
    assign o_stat.ovf    = r_ovf;
    assign o_data = r_odata;
    assign o_user = r_ouser;

endmodule

// File: hdl/fra_ctrl.sv
// ----------------------------------------------------------------------------
// fra_ctrl
// Controller: sequences euclid steps, two divisions, the split products
// and the sum update; owns both handshakes.
// ----------------------------------------------------------------------------
module fra_ctrl #(
    parameter int PART_WIDTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  fra_pkg::t_stat i_stat,
    output fra_pkg::t_cmd  o_cmd
);
    import fra_pkg::*;

    localparam int CW = $clog2(PART_WIDTH + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_GCD_CHK = 4'd1;
    localparam logic [3:0] S_GCD_DIV = 4'd2;
    localparam logic [3:0] S_RED     = 4'd3;
    localparam logic [3:0] S_DIV_N   = 4'd4;
    localparam logic [3:0] S_DIV_D   = 4'd5;
    localparam logic [3:0] S_MUL_LO  = 4'd6;
    localparam logic [3:0] S_MUL_HI  = 4'd7;
    localparam logic [3:0] S_MUL_CMB = 4'd8;
    localparam logic [3:0] S_ADD     = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [1:0]    r_sel, n_sel;
    logic          r_ovalid, n_ovalid;
    logic          w_cnt_end;

    assign w_cnt_end = (r_cnt == CW'(PART_WIDTH));

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_sel    = r_sel;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd    = '0;
        o_cmd.mul_sel = r_sel;
        o_cmd.div_sel = DIV_GCD;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_GCD_CHK;
                end
            end
            S_GCD_CHK: begin
                n_cnt = '0;
                if (i_stat.b_zero) begin
                    o_cmd.take_g = 1'b1;
                    n_state = S_RED;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_GCD_DIV;
                end
            end
            S_GCD_DIV: begin
                if (w_cnt_end) begin
                    o_cmd.gcd_next = 1'b1;
                    n_state = S_GCD_CHK;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_RED: begin
                n_cnt = '0;
                if (i_stat.g_zero) begin
                    o_cmd.pass_zoz = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_sel = DIV_NUM;
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV_N;
                end
            end
            S_DIV_N: begin
                if (w_cnt_end) begin
                    o_cmd.take_rn = 1'b1;
                    o_cmd.div_sel = DIV_DEN;
                    o_cmd.div_start = 1'b1;
                    n_cnt = '0;
                    n_state = S_DIV_D;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DIV_D: begin
                if (w_cnt_end) begin
                    o_cmd.take_rd = 1'b1;
                    n_sel = MUL_SN_RD;
                    n_state = i_stat.ovf ? S_DONE : S_MUL_LO;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state = S_MUL_CMB;
            end
            S_MUL_CMB: begin
                o_cmd.mul_cmb = 1'b1;
                if (r_sel == MUL_SD_RD) begin
                    n_state = S_ADD;
                end else begin
                    n_sel = r_sel + 1'b1;
                    n_state = S_MUL_LO;
                end
            end
            S_ADD: begin
                o_cmd.commit = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                // wait for the previous beat to leave the output register
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_sel    <= MUL_SN_RD;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_sel    <= n_sel;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

endmodule

// File: hdl/fraction_reduce_accumulate_top.sv
// ----------------------------------------------------------------------------
// fraction_reduce_accumulate_top
// Reduces each fraction by its gcd (euclid) and adds it to an unreduced
// running sum with a sticky 64-bit overflow flag.
//
//   channel  direction  tdata (low bit up)                tuser
//   s        in         numerator 16, denominator 16      clear_sum
//   m        out        reduced num 16, reduced den 16,   overflow, zero_over_zero
//                       total num 64, total den 64
//
// one beat at a time; with W = PART_WIDTH, an item runs E euclid remainder
// steps and two reductions, then the split products and the sum update
// (skipped once the overflow flag is set); a 0/0 input skips the reductions and the sum update
// each division runs on the shared W-step restoring divider
// synchronous active-low reset; sum restarts at 0/1, no clearing pass
// a stalled result sits in the output register while the next beat is worked
// ----------------------------------------------------------------------------
module fraction_reduce_accumulate_top #(
    parameter int PART_WIDTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [31:0]  i_s_tdata,   // numerator, denominator
    input  logic [0:0]   i_s_tuser,   // clear_sum
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [159:0] o_m_tdata,   // red num, red den, total num, total den
    output logic [1:0]   o_m_tuser    // overflow, zero_over_zero
);
    import fra_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    fra_ctrl #(.PART_WIDTH(PART_WIDTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    fra_dp #(.PART_WIDTH(PART_WIDTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_num   (i_s_tdata[15:0]),
        .i_den   (i_s_tdata[31:16]),
        .i_clr   (i_s_tuser[0]),
        .o_data  (o_m_tdata),
        .o_user  (o_m_tuser)
    );

    // one item in flight: after an accepted beat ready drops
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while busy");

    // 0/0 is passed through as 0/0
    a_zoz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tdata[31:0] == 32'd0)
        else $error("zero over zero with nonzero fraction");

    // the sum update and an input accept never share a cycle
    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> !o_s_tready)
        else $error("sum update while idle");

endmodule
